// File: rtl/multiword_by_word_division_defines.svh
// assertion macros for the multiword divider
`ifndef MULTIWORD_BY_WORD_DIVISION_DEFINES_SVH
`define MULTIWORD_BY_WORD_DIVISION_DEFINES_SVH

`ifndef ASSERT_OFF
`define MWDIV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MWDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MWDIV_ASSERT_SAME(lbl, ante, cons, msg)
`define MWDIV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/mwdiv_pkg.sv
`default_nettype none

package mwdiv_pkg;

    localparam int LIMB_BITS = 64;
    localparam int WORD_BITS = 64;
    localparam int CNT_W     = $clog2(LIMB_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: rtl/multiword_by_word_division.sv
`default_nettype none
`include "multiword_by_word_division_defines.svh"

// channel   handshake                  payload
// in        i_in_valid / o_in_ready    i_limb, i_dividend_negative, i_last_limb
// out       o_out_valid / i_out_ready  o_quotient_limb, o_remainder,
//                                      o_quotient_negative, o_is_last,
//                                      o_divide_by_zero
// cfg       i_cfg_we                   i_cfg_wdata
//
// a limb is loaded into the unit on transfer, and the unit then makes one quotient
// bit per cycle in the shared restoring unit; the result then passes through the
// done state into the result register. a zero divisor skips the unit.
// the next limb is taken once the current one has left the unit, while the
// result may still wait in the output register; a stalled output holds the
// finished limb in the done state. synchronous active-low reset.

module multiword_by_word_division
    import mwdiv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [63:0]           i_limb,
    input  wire logic                  i_dividend_negative,
    input  wire logic                  i_last_limb,
    input  wire logic                  i_cfg_we,
    input  wire logic signed [63:0]    i_cfg_wdata,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [63:0]                o_quotient_limb,
    output logic signed [63:0]         o_remainder,
    output logic                       o_quotient_negative,
    output logic                       o_is_last,
    output logic                       o_divide_by_zero
);

    t_state               r_state, n_state;
    t_div_ctrl            div_ctrl;
    t_div_stat            div_stat;
    logic [LIMB_BITS-1:0] div_q;
    logic [WORD_BITS-1:0] div_rem;

    logic [WORD_BITS-1:0] r_mag;
    logic                 r_dsr_neg;
    logic [WORD_BITS-1:0] r_part_rem;
    logic                 r_seen;
    logic                 r_dvd_neg;
    logic                 r_last;
    logic                 r_dbz;

    logic                 r_out_valid;
    logic [63:0]          r_q_out;
    logic signed [63:0]   r_rem_out;
    logic                 r_qneg_out;
    logic                 r_last_out;
    logic                 r_dbz_out;

    logic                 in_xfer;
    logic                 slot_free;
    logic                 out_load;
    logic                 mag_zero;
    logic                 seen_next;
    logic [WORD_BITS-1:0] rem_signed;

    mwdiv_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .i_limb  (i_limb[LIMB_BITS-1:0]),
        .i_mag   (r_mag),
        .i_rem   (r_part_rem),
        .o_stat  (div_stat),
        .o_q     (div_q),
        .o_rem   (div_rem)
    );

    assign mag_zero  = (r_mag == '0);
    assign slot_free = !r_out_valid || i_out_ready;
    assign in_xfer   = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = mag_zero ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready     = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                div_ctrl.start = i_in_valid && !mag_zero;
            end
            S_RUN:  ;
            S_DONE: out_load = slot_free;
            default: ;
        endcase
    end

    assign seen_next  = r_seen || (div_q != '0);
    assign rem_signed = r_dvd_neg ? (WORD_BITS'(0) - div_rem) : div_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mag       <= WORD_BITS'(1);
            r_dsr_neg   <= 1'b0;
            r_part_rem  <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_dsr_neg  <= i_cfg_wdata[63];
                r_mag      <= i_cfg_wdata[63] ? (64'd0 - i_cfg_wdata) : i_cfg_wdata;
                r_part_rem <= '0;
                r_seen     <= 1'b0;
            end else if (out_load) begin
                if (r_last) begin
                    r_part_rem <= '0;
                    r_seen     <= 1'b0;
                end else if (!r_dbz) begin
                    r_part_rem <= div_rem;
                    r_seen     <= seen_next;
                end
            end
        end
    end

    // item fields and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dvd_neg <= i_dividend_negative;
            r_last    <= i_last_limb;
            r_dbz     <= mag_zero;
        end
        if (out_load) begin
            r_last_out <= r_last;
            r_dbz_out  <= r_dbz;
            if (r_dbz) begin
                r_q_out    <= '0;
                r_rem_out  <= '0;
                r_qneg_out <= 1'b0;
            end else begin
                r_q_out    <= 64'(div_q);
                r_rem_out  <= r_last ? rem_signed : '0;
                r_qneg_out <= r_last && seen_next && (r_dvd_neg != r_dsr_neg);
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_quotient_limb     = r_q_out;
    assign o_remainder         = r_rem_out;
    assign o_quotient_negative = r_qneg_out;
    assign o_is_last           = r_last_out;
    assign o_divide_by_zero    = r_dbz_out;

    `MWDIV_ASSERT_SAME(a_busy_not_ready, div_stat.busy, !o_in_ready, "ready while unit busy")
    `MWDIV_ASSERT_NEXT(a_xfer_then_busy, in_xfer, !o_in_ready, "ready right after transfer")
    `MWDIV_ASSERT_SAME(a_rem_lt, r_state == S_DONE && !r_dbz, div_rem < r_mag, "rem >= divisor")
    `MWDIV_ASSERT_SAME(a_mid_rem, o_out_valid && !o_is_last, o_remainder == '0, "inner remainder")

endmodule

`default_nettype wire

// File: rtl/mwdiv_unit.sv
`default_nettype none

module mwdiv_unit
    import mwdiv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_div_ctrl            i_ctrl,
    input  wire logic [LIMB_BITS-1:0] i_limb,
    input  wire logic [WORD_BITS-1:0] i_mag,
    input  wire logic [WORD_BITS-1:0] i_rem,
    output t_div_stat                 o_stat,
    output logic [LIMB_BITS-1:0]      o_q,
    output logic [WORD_BITS-1:0]      o_rem
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_rem, n_rem;
    logic [LIMB_BITS-1:0] r_limb, n_limb;
    logic [LIMB_BITS-1:0] r_q, n_q;

    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    // one restoring step per cycle
    always_comb begin
        trial = {r_rem, r_limb[LIMB_BITS-1]};
        diff  = trial - {1'b0, i_mag};
        ge    = (trial >= {1'b0, i_mag});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_limb = r_limb;
        n_q    = r_q;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(LIMB_BITS);
            n_rem  = i_rem;
            n_limb = i_limb;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem  = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            n_limb = {r_limb[LIMB_BITS-2:0], 1'b0};
            n_q    = {r_q[LIMB_BITS-2:0], ge};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_limb <= n_limb;
        r_q    <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q         = r_q;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mwdiv_pkg::*;

    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_S = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMB_MASK =
        (LIMB_BITS >= 64) ? ONES : ((64'd1 << LIMB_BITS) - 64'd1);
    localparam int RANDOM_LIMBS  = 800;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DIRECTED_ROWS = 26;

    typedef enum logic {ROW_CFG, ROW_LIMB} t_row_kind;

    typedef struct packed {
        logic [63:0] quot;
        logic [63:0] rem;
        logic        qneg;
        logic        last;
        logic        dz;
    } t_quot_result;

    typedef struct packed {
        t_row_kind    kind;
        logic [63:0]  value;
        logic         neg;
        logic         last;
        logic         typed;
        t_quot_result want;
    } t_step;

    localparam t_quot_result NONE = '0;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [63:0]        i_limb;
    logic               i_dividend_negative;
    logic               i_last_limb;
    logic               i_cfg_we;
    logic [63:0]        i_cfg_wdata;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [63:0]        o_quotient_limb;
    logic signed [63:0] o_remainder;
    logic               o_quotient_negative;
    logic               o_is_last;
    logic               o_divide_by_zero;

    multiword_by_word_division DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_limb              (i_limb),
        .i_dividend_negative (i_dividend_negative),
        .i_last_limb         (i_last_limb),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_quotient_limb     (o_quotient_limb),
        .o_remainder         (o_remainder),
        .o_quotient_negative (o_quotient_negative),
        .o_is_last           (o_is_last),
        .o_divide_by_zero    (o_divide_by_zero)
    );

    // divisor state mirrored by the predictor
    logic [63:0]  divisor_q;
    logic [63:0]  running_rem;
    logic         quot_nonzero;
    t_quot_result expected_limbs[$];

    int  errors;
    int  limbs_sent;
    int  numbers_done;
    int  divisor_writes;
    int  results_checked;
    int  quiet;
    int  stall_left;
    logic in_rush;
    logic out_rush;

    t_step directed [DIRECTED_ROWS] = '{
        '{ROW_LIMB, ONES, 1'b0, 1'b1, 1'b1, '{ONES, 64'd0, 1'b0, 1'b1, 1'b0}},
        '{ROW_LIMB, 64'd0, 1'b1, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b1, 1'b0}},
        '{ROW_LIMB, 64'd1, 1'b0, 1'b0, 1'b1, '{64'd1, 64'd0, 1'b0, 1'b0, 1'b0}},
        '{ROW_LIMB, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 1'b1,
          '{64'h0123_4567_89AB_CDEF, 64'd0, 1'b1, 1'b1, 1'b0}},
        '{ROW_CFG, 64'd0, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd123, 1'b1, 1'b0, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_LIMB, ONES, 1'b1, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b1, 1'b1}},
        '{ROW_CFG, ONES, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd5, 1'b0, 1'b1, 1'b1, '{64'd5, 64'd0, 1'b1, 1'b1, 1'b0}},
        '{ROW_CFG, MIN_S, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, ONES, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, ONES, 1'b1, 1'b1, 1'b0, NONE},
        '{ROW_CFG, MAX_S, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, ONES, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd0, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, ONES, 1'b1, 1'b1, 1'b0, NONE},
        '{ROW_CFG, 64'd7, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd100, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_CFG, 64'd3, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd10, 1'b1, 1'b1, 1'b0, NONE},
        '{ROW_CFG, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'd1, 1'b0, 1'b1, 1'b0, NONE},
        '{ROW_LIMB, 64'd25, 1'b1, 1'b1, 1'b0, NONE},
        '{ROW_LIMB, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, NONE},
        '{ROW_LIMB, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0, NONE},
        '{ROW_CFG, 64'd1, 1'b0, 1'b0, 1'b0, NONE}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_quot_result divide_limb_by_divisor(logic [63:0] limb, logic neg,
                                                            logic last);
        t_quot_result res;
        logic         dsr_neg;
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] quo;
        res = '0;
        res.last = last;
        dsr_neg = divisor_q[63];
        mag = dsr_neg ? (~divisor_q + 64'd1) : divisor_q;
        if (mag == 64'd0) begin
            res.dz = 1'b1;
        end else begin
            num = ({64'd0, running_rem} << LIMB_BITS) | {64'd0, limb & LIMB_MASK};
            quo = num / {64'd0, mag};
            running_rem = 64'(num % {64'd0, mag});
            res.quot = 64'(quo) & LIMB_MASK;
            if (res.quot != 64'd0)
                quot_nonzero = 1'b1;
            if (last) begin
                res.rem  = neg ? (~running_rem + 64'd1) : running_rem;
                res.qneg = quot_nonzero && (neg != dsr_neg);
            end
        end
        if (last) begin
            running_rem  = 64'd0;
            quot_nonzero = 1'b0;
        end
        return res;
    endfunction

    function automatic void add_expected(t_quot_result res);
        expected_limbs.insert(expected_limbs.size(), res);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [63:0] pick_divisor();
        int          r;
        logic [63:0] v;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            v = 64'd0;
        end else if (r == 1) begin
            case ($urandom_range(0, 3))
                0: v = 64'd1;
                1: v = ONES;
                2: v = MIN_S;
                default: v = MAX_S;
            endcase
        end else if (r < 8) begin
            v = 64'($urandom_range(1, 16));
        end else if (r < 12) begin
            v = 64'd1 << $urandom_range(0, 62);
        end else begin
            v = {$urandom, $urandom};
        end
        if (r > 1 && r < 12 && $urandom_range(0, 1) == 1)
            v = ~v + 64'd1;
        return v;
    endfunction

    function automatic logic [63:0] pick_limb();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return ONES;
            2: return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_divisor(input logic [63:0] value);
        i_in_valid = 1'b0;
        while (expected_limbs.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        divisor_q    = value;
        running_rem  = 64'd0;
        quot_nonzero = 1'b0;
        divisor_writes++;
    endtask

    task automatic send_limb(input logic [63:0] limb, input logic neg, input logic last,
                             input logic typed, input t_quot_result want);
        t_quot_result pred;
        int           gap;
        i_limb              = limb;
        i_dividend_negative = neg;
        i_last_limb         = last;
        i_in_valid          = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pred = divide_limb_by_divisor(limb, neg, last);
        add_expected(typed ? want : pred);
        limbs_sent++;
        if (last)
            numbers_done++;
        @(negedge i_clk);
        gap = in_rush ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%016h, got 0x%016h", name, want, got);
            errors++;
        end
    endtask

    // output side stalls
    always @(negedge i_clk) begin
        if (stall_left == 0 && !out_rush && $urandom_range(0, 3) == 0)
            stall_left = gap_len();
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_quot_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_limbs.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_res = expected_limbs.pop_front();
                compare_field("quotient_limb", exp_res.quot, o_quotient_limb);
                compare_field("remainder", exp_res.rem, o_remainder);
                compare_field("quotient_negative", 64'(exp_res.qneg), 64'(o_quotient_negative));
                compare_field("is_last", 64'(exp_res.last), 64'(o_is_last));
                compare_field("divide_by_zero", 64'(exp_res.dz), 64'(o_divide_by_zero));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("multiword_by_word_division test failed");
            $finish;
        end
    end

    initial begin
        int numbers;
        int len;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_limb              = 64'd0;
        i_dividend_negative = 1'b0;
        i_last_limb         = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 64'd0;
        i_out_ready         = 1'b0;
        stall_left          = 0;
        in_rush             = 1'b0;
        out_rush            = 1'b0;
        errors              = 0;
        limbs_sent          = 0;
        numbers_done        = 0;
        divisor_writes      = 0;
        results_checked     = 0;
        quiet               = 0;
        divisor_q           = 64'd1;
        running_rem         = 64'd0;
        quot_nonzero        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_CFG)
                write_divisor(directed[i].value);
            else
                send_limb(directed[i].value, directed[i].neg, directed[i].last,
                          directed[i].typed, directed[i].want);
        end

        while (limbs_sent < DIRECTED_ROWS + RANDOM_LIMBS) begin
            write_divisor(pick_divisor());
            in_rush  = ($urandom_range(0, 4) == 0);
            out_rush = ($urandom_range(0, 4) == 0);
            numbers  = $urandom_range(1, 6);
            for (int n = 0; n < numbers; n++) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    send_limb(pick_limb(), 1'($urandom), k == len - 1, 1'b0, NONE);
            end
            // leave a number unfinished so the next divisor write abandons it
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    send_limb(pick_limb(), 1'($urandom), 1'b0, 1'b0, NONE);
            end
        end

        i_in_valid = 1'b0;
        out_rush   = 1'b0;
        while (expected_limbs.size() != 0)
            @(posedge i_clk);
        repeat (LIMB_BITS + 8) @(posedge i_clk);

        $display("%0d limbs sent, %0d numbers completed, %0d divisor writes",
                 limbs_sent, numbers_done, divisor_writes);
        $display("%0d results checked, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("multiword_by_word_division test passed");
        else
            $display("multiword_by_word_division test failed");
        $finish;
    end

endmodule
